// ===== sv/box_blur_line_filter_unit_assert.svh =====
// Assertion shorthands for the box blur line filter. Both expect i_clk and
// i_rst_n in scope and are disabled while reset is asserted.
`ifndef BOX_BLUR_LINE_FILTER_UNIT_ASSERT_SVH
`define BOX_BLUR_LINE_FILTER_UNIT_ASSERT_SVH

// The consequence holds in the same cycle as the antecedent.
`define BBLF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define BBLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bblf_pkg.sv =====
package bblf_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int PIXEL_W      = 3 * CHANNEL_BITS;
    localparam int RADIUS_W     = 4;

    typedef logic [PIXEL_W-1:0]      t_pixel;
    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [RADIUS_W-1:0]     t_radius;

    localparam t_radius RADIUS_RESET = t_radius'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_SEND
    } t_state;

endpackage

// ===== sv/bblf_in_if.sv =====
interface bblf_in_if
    import bblf_pkg::*;
;
    logic   valid;
    logic   ready;
    t_pixel in_pixel;
    logic   in_last;

    modport source (output valid, output in_pixel, output in_last, input ready);
    modport sink   (input valid, input in_pixel, input in_last, output ready);
endinterface

// ===== sv/bblf_out_if.sv =====
interface bblf_out_if
    import bblf_pkg::*;
;
    logic   valid;
    logic   ready;
    t_pixel out_pixel;
    logic   out_last;

    modport source (output valid, output out_pixel, output out_last, input ready);
    modport sink   (input valid, input out_pixel, input out_last, output ready);
endinterface

// ===== sv/bblf_cfg_if.sv =====
interface bblf_cfg_if
    import bblf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_radius blur_radius;

    modport source (output valid, output blur_radius, input ready);
    modport sink   (input valid, input blur_radius, output ready);
endinterface

// ===== sv/bblf_ram.sv =====
module bblf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/box_blur_line_filter_unit.sv =====
// Box blur line filter: running-sum horizontal or vertical blur of one line.
// Channels: i_pix takes pixels of a line in order, in_last on the final one;
// o_pix returns blurred pixels, out_last on the final one; i_cfg writes the
// blur radius (always ready, latched at the first pixel of each line).
// A pixel is taken only in the idle state; a pixel that completes no output
// window leaves the block idle for the next one. A pixel that completes a
// window then passes through a state for the reciprocal multiply and the
// window memory read and a state that updates the sums and loads the output
// register, and input waits until the block is back in the idle state.
// The final pixel of a line flushes every output still owed, each one through
// the multiply and update states in turn.
// The rate is set by the registered read of the window memory and the
// registered divide-by-window multiply.
// A single output register parts the two sides: input is accepted while a
// result waits. If the receiver stalls while a new result is ready, the
// block holds in a wait state until the register frees.
// Reset clears the line counters and sets the radius to 8; the window memory
// needs no clearing, since every entry is written before it is read.
module box_blur_line_filter_unit
    import bblf_pkg::*;
#(
    parameter int MAX_RADIUS = 15,
    parameter int MAX_LINE   = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bblf_cfg_if.sink    i_cfg,
    bblf_in_if.sink     i_pix,
    bblf_out_if.source  o_pix
);

    `include "box_blur_line_filter_unit_assert.svh"

    // Radius, window count and sum widths all follow from the largest radius.
    localparam int RW        = $clog2(MAX_RADIUS + 1);
    localparam int DW        = $clog2(2 * MAX_RADIUS + 2);
    localparam int AW        = DW;
    localparam int WIN_DEPTH = 2 ** DW;
    localparam int SUM_W     = CHANNEL_BITS + DW;
    // Reciprocal scaling: exact truncated quotient for every sum in range.
    localparam int K         = SUM_W + DW;
    localparam int M_W       = K + 1;
    localparam int PROD_W    = SUM_W + M_W;
    localparam int LINE_W    = $clog2(MAX_LINE);
    localparam int CW        = ((LINE_W > RW) ? LINE_W : RW) + 1;

    // Reciprocal table, ceil(2^K / (2r + 1)) for each radius.
    logic [M_W-1:0] recip_tab [MAX_RADIUS+1];

    for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
        localparam longint unsigned RECIP = ((64'd1 << K) + 2 * g) / (2 * g + 1);
        assign recip_tab[g] = M_W'(RECIP);
    end

    t_state            r_state;
    t_state            n_state;
    t_radius           r_blur_radius;
    logic [RW-1:0]     r_line_r;
    logic [M_W-1:0]    r_recip;
    logic [LINE_W-1:0] r_seen;
    logic [LINE_W-1:0] r_sent;
    logic [LINE_W-1:0] r_cur_m;
    t_pixel            r_px;
    logic              r_flush;
    logic [SUM_W-1:0]  r_sum  [3];
    logic [PROD_W-1:0] r_prod [3];
    logic              r_out_valid;
    t_pixel            r_out_pixel;
    logic              r_out_last;

    logic              accept;
    logic              first;
    logic              last_eff;
    logic              emit_now;
    logic [RW-1:0]     radius_new;
    logic [CW-1:0]     m_ext;
    logic [CW-1:0]     jr_ext;
    logic [CW-1:0]     j_ext;
    logic [CW-1:0]     r_ext;
    logic [DW-1:0]     pad;
    logic [DW-1:0]     times;
    logic [CW-1:0]     left_idx;
    logic              has_drop;
    logic              is_final;
    logic              out_free;
    logic              load;
    logic              rd_en;
    t_pixel            rd_data;
    t_pixel            out_word;
    logic [SUM_W-1:0]  n_sum_acc [3];
    logic [SUM_W-1:0]  n_sum_upd [3];

    // Configuration is always accepted.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blur_radius <= RADIUS_RESET;
        end else if (i_cfg.valid) begin
            r_blur_radius <= i_cfg.blur_radius;
        end
    end

    // Per-pixel bookkeeping for the accept cycle.
    always_comb begin
        first      = (r_seen == '0);
        radius_new = (int'(r_blur_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS)
                                                        : RW'(r_blur_radius);
        m_ext      = CW'(r_seen);
        j_ext      = CW'(r_sent);
        r_ext      = first ? CW'(radius_new) : CW'(r_line_r);
        jr_ext     = j_ext + r_ext;
        last_eff   = i_pix.in_last || (int'(r_seen) == MAX_LINE - 1);
        // Pad the right edge with the final pixel for windows past the end.
        pad        = (last_eff && (jr_ext > m_ext)) ? DW'(jr_ext - m_ext) : '0;
        times      = (first ? (DW'(r_ext) + DW'(1)) : DW'(1)) + pad;
        emit_now   = last_eff || (m_ext == jr_ext);
        for (int c = 0; c < 3; c++) begin
            n_sum_acc[c] = (first ? '0 : r_sum[c])
                         + SUM_W'(i_pix.in_pixel[c*CHANNEL_BITS +: CHANNEL_BITS])
                           * SUM_W'(times);
        end
    end

    // Left end of the current window, clamped to the first pixel.
    always_comb begin
        left_idx = (CW'(r_sent) >= CW'(r_line_r)) ? (CW'(r_sent) - CW'(r_line_r)) : '0;
        is_final = r_flush && (r_sent == r_cur_m);
        has_drop = !is_final;
        for (int c = 0; c < 3; c++) begin
            n_sum_upd[c] = r_sum[c]
                         - SUM_W'(rd_data[c*CHANNEL_BITS +: CHANNEL_BITS])
                         + (r_flush ? SUM_W'(r_px[c*CHANNEL_BITS +: CHANNEL_BITS])
                                    : '0);
            out_word[c*CHANNEL_BITS +: CHANNEL_BITS] = r_prod[c][K +: CHANNEL_BITS];
        end
    end

    bblf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (m_ext[AW-1:0]),
        .i_wr_data (i_pix.in_pixel),
        .i_rd_en   (rd_en),
        .i_rd_addr (left_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pix.valid && emit_now) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD, ST_SEND: begin
                if (!out_free) begin
                    n_state = ST_SEND;
                end else if (r_flush && !is_final) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        out_free    = !r_out_valid || o_pix.ready;
        i_pix.ready = (r_state == ST_IDLE);
        accept      = (r_state == ST_IDLE) && i_pix.valid;
        rd_en       = (r_state == ST_MUL);
        load        = ((r_state == ST_UPD) || (r_state == ST_SEND)) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= '0;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
            r_line_r    <= '0;
            r_flush     <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_seen  <= r_seen + LINE_W'(1);
                r_cur_m <= r_seen;
                r_px    <= i_pix.in_pixel;
                r_flush <= last_eff;
                if (first) begin
                    r_line_r <= radius_new;
                    r_recip  <= recip_tab[radius_new];
                end
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= n_sum_acc[c];
                end
            end
            if (r_state == ST_MUL) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[c] <= PROD_W'(r_sum[c]) * PROD_W'(r_recip);
                end
            end
            // Slide the window: drop its left end, and on a flush bring in
            // another copy of the final pixel.
            if ((r_state == ST_UPD) && has_drop) begin
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= n_sum_upd[c];
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
                r_out_pixel <= out_word;
                r_out_last  <= is_final;
                if (is_final) begin
                    r_seen <= '0;
                    r_sent <= '0;
                end else begin
                    r_sent <= r_sent + LINE_W'(1);
                end
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_pixel = r_out_pixel;
    assign o_pix.out_last  = r_out_last;

    `BBLF_ASSERT_SAME(a_sent_le_seen, r_state == ST_IDLE, r_sent <= r_seen,
        "more outputs sent than pixels received")
    `BBLF_ASSERT_SAME(a_sent_le_cur, r_state == ST_UPD || r_state == ST_SEND,
        r_sent <= r_cur_m, "output index ran past the current pixel")
    `BBLF_ASSERT_SAME(a_no_overwrite, load, !r_out_valid || o_pix.ready,
        "output register overwritten while a result waits")
    `BBLF_ASSERT_NEXT(a_line_cleared, load && is_final, r_seen == '0 && r_sent == '0,
        "line counters not cleared after the final output")

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bblf_pkg::*;

    // Block limits as built with the default parameters.
    localparam int MAX_RADIUS     = 15;
    localparam int MAX_LINE       = 2048;
    localparam int WINDOW_DEPTH   = 2 * MAX_RADIUS + 2;

    // The worst flush sends a full window of outputs, so this many quiet
    // cycles after the last result leave the block idle.
    localparam int DRAIN_CYCLES   = 2 * (MAX_RADIUS + 1) + 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS    = 40;
    localparam int ITEMS_PER_STEP = 4;

    // One pixel of a line, used both for stimulus and for predicted output.
    typedef struct packed {
        t_pixel pixel;
        logic   last;
    } t_pix_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bblf_cfg_if cfg_if ();
    bblf_in_if  pix_if ();
    bblf_out_if out_if ();

    box_blur_line_filter_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_pix   (pix_if.sink),
        .o_pix   (out_if.source)
    );

    always #2 i_clk = ~i_clk;

    // Pixels waiting to be offered, and blurred pixels still owed by the block.
    t_pix_item pixel_q [$];
    t_pix_item blurred_q [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    logic rx_hold      = 1'b0;

    // ------------------------------------------------------------------
    // Running-sum blur predictor. It keeps its own copy of the line buffer,
    // the three channel sums and the line counters, and pushes the blurred
    // pixels that each accepted input pixel releases.
    // ------------------------------------------------------------------
    t_radius     radius_reg = RADIUS_RESET;
    t_pixel      line_buf [WINDOW_DEPTH];
    int unsigned win_sum [3];
    int unsigned seen_cnt = 0;
    int unsigned sent_cnt = 0;
    int unsigned line_rad = 0;

    // Channel 2 is red (top byte), channel 0 is blue.
    function automatic int unsigned chan_of(t_pixel px, int sel);
        return px[sel*CHANNEL_BITS +: CHANNEL_BITS];
    endfunction

    function automatic void add_to_sums(t_pixel px, int unsigned times);
        for (int c = 0; c < 3; c++)
            win_sum[c] += chan_of(px, c) * times;
    endfunction

    // Remove the left end of output j's window; positions left of the line
    // start stand for the first pixel.
    function automatic void drop_left(int unsigned j);
        t_pixel px;
        px = line_buf[(j >= line_rad ? j - line_rad : 0) % WINDOW_DEPTH];
        for (int c = 0; c < 3; c++)
            win_sum[c] -= chan_of(px, c);
    endfunction

    function automatic void push_blurred(logic last);
        t_pix_item   res;
        int unsigned span;
        span      = 2 * line_rad + 1;
        res.pixel = {t_chan'(win_sum[2] / span), t_chan'(win_sum[1] / span),
                     t_chan'(win_sum[0] / span)};
        res.last  = last;
        blurred_q.push_back(res);
    endfunction

    function automatic void blur_line_step(t_pixel px, logic last_in);
        int unsigned m;
        int unsigned j;
        logic        ends;
        m    = seen_cnt;
        j    = sent_cnt;
        ends = last_in;
        if (m == 0) begin
            // The radius is latched here, so a write mid-line only affects
            // the next line. The left edge repeats the first pixel.
            line_rad = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
            win_sum  = '{0, 0, 0};
            add_to_sums(px, line_rad + 1);
        end else begin
            add_to_sums(px, 1);
        end
        line_buf[m % WINDOW_DEPTH] = px;
        seen_cnt = m + 1;
        // A line that runs to the size limit ends there as if marked last.
        if (m + 1 >= MAX_LINE)
            ends = 1'b1;
        if (!ends) begin
            if (m == j + line_rad) begin
                push_blurred(1'b0);
                drop_left(j);
                sent_cnt = j + 1;
            end
        end else begin
            // Pad the right side with the final pixel and flush the rest.
            if (j + line_rad > m)
                add_to_sums(px, j + line_rad - m);
            while (j <= m) begin
                push_blurred(j == m);
                if (j < m) begin
                    drop_left(j);
                    add_to_sums(px, 1);
                end
                j++;
            end
            win_sum  = '{0, 0, 0};
            seen_cnt = 0;
            sent_cnt = 0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Pixel driver. A transfer happens at an edge where valid and ready are
    // both high; the predictor runs on that transfer. A new pixel is offered
    // only when the slot is empty or has just been taken, and the sender
    // idles at random by the current percentage.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready)
                blur_line_step(pix_if.in_pixel, pix_if.in_last);
            if (!pix_if.valid || pix_if.ready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    pix_if.valid    <= 1'b1;
                    pix_if.in_pixel <= pixel_q[0].pixel;
                    pix_if.in_last  <= pixel_q[0].last;
                    void'(pixel_q.pop_front());
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Each output transfer is compared field by field with
    // the oldest predicted pixel. Ready drops at random, and stays low for
    // the whole of a forced receiver hold-off.
    // ------------------------------------------------------------------
    t_pix_item front_result;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (blurred_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel %h last %b",
                                              out_if.out_pixel, out_if.out_last));
                end else begin
                    front_result = blurred_q.pop_front();
                    if (out_if.out_pixel !== front_result.pixel)
                        report_mismatch($sformatf("pixel %h, predicted %h",
                                                  out_if.out_pixel, front_result.pixel));
                    if (out_if.out_last !== front_result.last)
                        report_mismatch($sformatf("last %b, predicted %b (pixel %h)",
                                                  out_if.out_last, front_result.last,
                                                  front_result.pixel));
                end
            end
            out_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. The sequence below works at falling edges so that
    // queue pushes never race the clocked processes.
    // ------------------------------------------------------------------

    // Channels favor the rails so that saturated sums occur often.
    function automatic t_pixel pick_pixel();
        t_pixel px;
        for (int c = 0; c < 3; c++)
            case ($urandom_range(5))
                0:       px[c*CHANNEL_BITS +: CHANNEL_BITS] = '0;
                1:       px[c*CHANNEL_BITS +: CHANNEL_BITS] = '1;
                default: px[c*CHANNEL_BITS +: CHANNEL_BITS] = t_chan'($urandom);
            endcase
        return px;
    endfunction

    // Mostly short lines, some longer than the widest window.
    function automatic int pick_length();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return $urandom_range(16, 1);
        else if (sel < 9)
            return $urandom_range(40, 17);
        return $urandom_range(64, 41);
    endfunction

    task automatic push_pixel(t_pixel px, logic last);
        t_pix_item item;
        item.pixel = px;
        item.last  = last;
        pixel_q.push_back(item);
    endtask

    // Queue count random pixels; the final one closes the line if ends is set.
    task automatic push_pixels(int count, logic ends);
        for (int k = 0; k < count; k++)
            push_pixel(pick_pixel(), ends && (k == count - 1));
    endtask

    // Wait until every pixel has been taken and every blurred pixel has come
    // back, then give the block time to finish any flush still in flight.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || pix_if.valid || blurred_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_radius(t_radius r);
        @(posedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.blur_radius <= r;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        radius_reg = r;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    int items_left;
    int len;

    initial begin
        cfg_if.valid       = 1'b0;
        cfg_if.blur_radius = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 23;
        recv_idle_pct = 51;

        // Directed part. The first lines run at the reset radius of 8, which
        // is wider than the lines, so the right edge pads with the last pixel.
        push_pixel(24'hFFFFFF, 1'b0);
        push_pixel(24'h000000, 1'b0);
        push_pixel(24'hFFFFFF, 1'b1);
        push_pixel(24'hFFFFFF, 1'b1);   // single-pixel line
        wait_drained();

        // Radius zero passes pixels straight through.
        write_radius(t_radius'(0));
        push_pixel(24'h123456, 1'b0);
        push_pixel(24'hFEDCBA, 1'b1);
        push_pixel(24'h000000, 1'b1);
        wait_drained();

        // Widest window. Half a line goes in, the radius changes while the
        // block is between pixels, and the rest of the line must still use
        // the radius latched at its first pixel.
        write_radius(t_radius'(15));
        push_pixel(24'hFF0000, 1'b0);
        push_pixel(24'h00FF00, 1'b0);
        push_pixel(24'h0000FF, 1'b0);
        push_pixel(24'hFFFFFF, 1'b0);
        push_pixel(24'h000000, 1'b0);
        wait_drained();
        write_radius(t_radius'(3));
        push_pixel(24'hAA55AA, 1'b0);
        push_pixel(24'h55AA55, 1'b0);
        push_pixel(24'hFFFFFF, 1'b0);
        push_pixel(24'h010101, 1'b0);
        push_pixel(24'hFEFEFE, 1'b1);
        wait_drained();

        // Radius 3 now applies: alternating rails over a line longer than
        // the window.
        for (int k = 0; k < 8; k++)
            push_pixel(k[0] ? 24'hFFFFFF : 24'h000000, k == 7);
        wait_drained();

        // Random part in three idle settings, several radii in each.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 23; recv_idle_pct = 51; end
                1:       begin send_idle_pct = 51; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int step = 0; step < 4; step++) begin
                if (step == 0)
                    write_radius(phase == 0 ? t_radius'(0) :
                                 phase == 1 ? t_radius'(15) : t_radius'(1));
                else
                    write_radius(t_radius'($urandom_range(15)));

                if (phase == 0 && step == 1) begin
                    // The receiver holds off for a long stretch while a long
                    // line keeps coming, so the block fills and stalls input.
                    fork
                        begin
                            rx_hold <= 1'b1;
                            repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                            rx_hold <= 1'b0;
                        end
                    join_none
                    push_pixels(60, 1'b1);
                end else if (phase == 2 && step == 1) begin
                    // The sender stops mid-line until every owed pixel is back.
                    push_pixels(20, 1'b0);
                    wait_drained();
                    push_pixels(15, 1'b1);
                end else begin
                    items_left = ITEMS_PER_STEP;
                    while (items_left > 0) begin
                        len = pick_length();
                        push_pixels(len, 1'b1);
                        items_left -= len;
                    end
                end
                wait_drained();
            end
        end

        if (blurred_q.size() != 0)
            report_mismatch($sformatf("%0d predicted pixels never came",
                                      blurred_q.size()));
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
